// File: rtl/sof_bcc_crc16_frame_deframer_core_macros.svh
// Assertion macros for the SOF/BCC/CRC-16 frame deframer.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef SOF_BCC_CRC16_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SOF_BCC_CRC16_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SBCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SBCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbcc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the frame deframer.
// No dependencies; used by sbcc_out_skid and the top level.
package sbcc_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SOF_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_MASK   = 2'd2;

  // Register reset values
  localparam logic [7:0] SOF_RESET      = 8'h55;
  localparam logic [9:0] MIN_LEN_RESET  = 10'd13;
  localparam logic [7:0] ACK_MASK_RESET = 8'h80;

  // Frame geometry: 11 header bytes plus 2 CRC bytes
  localparam int         CRC_BYTES     = 2;
  localparam logic [9:0] MIN_FRAME_LEN = 10'd13;
  localparam int         FRAME_LEN_W   = 10;

  // Byte positions of the header fields after the BCC
  localparam int POS_TYPE     = 4;
  localparam int POS_SENDER   = 5;
  localparam int POS_RECEIVER = 6;
  localparam int POS_SEQ_LO   = 7;
  localparam int POS_SEQ_HI   = 8;
  localparam int POS_CMD_SET  = 9;
  localparam int POS_CMD_ID   = 10;

  // CRC-16, MSB first, no final XOR
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef struct packed {
    logic [7:0]             payload_byte;
    logic                   payload_valid;
    logic                   frame_end;
    logic                   crc_ok;
    logic                   is_ack;
    logic [7:0]             cmd_type;
    logic [7:0]             sender;
    logic [7:0]             receiver;
    logic [15:0]            sequence_res;
    logic [7:0]             command_set;
    logic [7:0]             command_id;
    logic [FRAME_LEN_W-1:0] frame_length;
  } result_t;

  // Advance the CRC by one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/sbcc_out_skid.sv
// Two-entry result buffer: output register plus one skid entry.
// Depends on sbcc_pkg for the result item type.
module sbcc_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  sbcc_pkg::result_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sbcc_pkg::result_t pop_data
);
  import sbcc_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    spare_vld_r, spare_vld_nxt;
  result_t head_r, head_nxt;
  result_t spare_r, spare_nxt;
  logic    pop;

  // Room exists as long as the skid entry is free
  assign push_ready = !spare_vld_r;
  assign pop_valid  = head_vld_r;
  assign pop_data   = head_r;
  assign pop        = head_vld_r && pop_ready;

  // Move items between head and skid entry
  always_comb begin
    head_vld_nxt  = head_vld_r;
    spare_vld_nxt = spare_vld_r;
    head_nxt      = head_r;
    spare_nxt     = spare_r;
    if (pop) begin
      if (spare_vld_r) begin
        head_nxt      = spare_r;
        spare_vld_nxt = 1'b0;
      end else if (push_valid) begin
        head_nxt = push_data;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else if (push_valid && !spare_vld_r) begin
      if (!head_vld_r) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        spare_nxt     = push_data;
        spare_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r  <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      head_vld_r  <= head_vld_nxt;
      spare_vld_r <= spare_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

endmodule

// File: rtl/sof_bcc_crc16_frame_deframer_core.sv
// Byte-stream frame deframer: hunts for a start byte, a little-endian length and
// a header BCC in a sliding four-byte window, captures the header fields, passes
// payload bytes on one result each and closes every frame with a record that
// carries the CRC-16 verdict. One byte is taken every clock cycle unless a result
// waits for buffer room: a byte is held in the input register, goes through the
// CRC-16 byte steps and the header compare, and is registered in the result buffer.
// Header bytes, hunting bytes and the low CRC byte produce no result. Up to two
// results are buffered, so a stalled output only holds the input back once full.
// Depends on sbcc_pkg, sbcc_out_skid and the assertion macro header.
module sof_bcc_crc16_frame_deframer_core #(
  parameter int LENGTH_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [sbcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input byte channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_payload_byte,
  output logic                           out_payload_valid,
  output logic                           out_frame_end,
  output logic                           out_crc_ok,
  output logic                           out_is_ack,
  output logic [7:0]                     out_cmd_type,
  output logic [7:0]                     out_sender,
  output logic [7:0]                     out_receiver,
  output logic [15:0]                    out_sequence_res,
  output logic [7:0]                     out_command_set,
  output logic [7:0]                     out_command_id,
  output logic [sbcc_pkg::FRAME_LEN_W-1:0] out_frame_length
);
  import sbcc_pkg::*;
  `include "sof_bcc_crc16_frame_deframer_core_macros.svh"

  localparam int LW = LENGTH_BITS;
  localparam int CMP_W = (LENGTH_BITS > FRAME_LEN_W) ? LENGTH_BITS : FRAME_LEN_W;

  // configuration registers
  logic [7:0] sof_value_r;
  logic [9:0] min_length_r;
  logic [7:0] ack_mask_r;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // hunt state
  logic [2:0][7:0] win_r, win_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic [15:0]     crc_a_r, crc_a_nxt;   // CRC from FFFF over window bytes 0..2
  logic [15:0]     crc_b_r, crc_b_nxt;   // over window bytes 1..2
  logic [15:0]     crc_c_r, crc_c_nxt;   // over window byte 2

  // frame state
  logic          in_frame_r, in_frame_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] length_r, length_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_lo_r, crc_lo_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    sender_r, sender_nxt;
  logic [7:0]    receiver_r, receiver_nxt;
  logic [15:0]   seq_r, seq_nxt;
  logic [7:0]    cmd_set_r, cmd_set_nxt;
  logic [7:0]    cmd_id_r, cmd_id_nxt;

  logic          proc_fire;
  logic          has_result;
  logic          sk_ready;
  result_t       res;
  result_t       out_data;
  logic [LW-1:0] len_m1;
  logic [LW-1:0] len_m2;
  logic [15:0]   win_field;
  logic [LW-1:0] win_len;
  logic [9:0]    min_len_eff;
  logic          hdr_ok;
  logic [CMP_W-1:0] length_ext;

  // configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_value_r  <= SOF_RESET;
      min_length_r <= MIN_LEN_RESET;
      ack_mask_r   <= ACK_MASK_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SOF_VALUE:  sof_value_r  <= cfg_wdata[7:0];
        REG_MIN_LENGTH: min_length_r <= cfg_wdata[9:0];
        REG_ACK_MASK:   ack_mask_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register: take a new item whenever the current one moves on
  assign in_ready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // frame geometry and header check
  assign len_m1      = length_r - LW'(1);
  assign len_m2      = length_r - LW'(CRC_BYTES);
  assign win_field   = {win_r[2], win_r[1]};
  assign win_len     = win_field[LW-1:0];
  assign min_len_eff = (min_length_r < MIN_FRAME_LEN) ? MIN_FRAME_LEN : min_length_r;
  assign hdr_ok      = (win_r[0] == sof_value_r) &&
                       (CMP_W'(win_len) >= CMP_W'(min_len_eff)) &&
                       ((win_r[0] ^ win_r[1] ^ win_r[2]) == in_byte_r);
  assign length_ext  = CMP_W'(length_r);

  // a result comes from payload bytes and from the last byte of a frame
  always_comb begin
    has_result = 1'b0;
    if (in_frame_r) begin
      has_result = !((pos_r >= LW'(POS_TYPE)) && (pos_r <= LW'(POS_CMD_ID))) &&
                   (pos_r != len_m2);
    end
  end

  // hold the byte while a result has no room
  assign proc_fire = in_valid_r && (!has_result || sk_ready);

  // build the result from the captured header fields
  always_comb begin
    res               = '0;
    res.is_ack        = (type_r & ack_mask_r) != 8'h00;
    res.cmd_type      = type_r;
    res.sender        = sender_r;
    res.receiver      = receiver_r;
    res.sequence_res  = seq_r;
    res.command_set   = cmd_set_r;
    res.command_id    = cmd_id_r;
    res.frame_length  = length_ext[FRAME_LEN_W-1:0];
    if (pos_r == len_m1) begin
      res.frame_end = 1'b1;
      res.crc_ok    = ({in_byte_r, crc_lo_r} == crc_r);
    end else begin
      res.payload_byte  = in_byte_r;
      res.payload_valid = 1'b1;
    end
  end

  // process one byte: hunt the header or advance through the frame
  always_comb begin
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    crc_a_nxt    = crc_a_r;
    crc_b_nxt    = crc_b_r;
    crc_c_nxt    = crc_c_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    length_nxt   = length_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    type_nxt     = type_r;
    sender_nxt   = sender_r;
    receiver_nxt = receiver_r;
    seq_nxt      = seq_r;
    cmd_set_nxt  = cmd_set_r;
    cmd_id_nxt   = cmd_id_r;
    if (proc_fire) begin
      if (!in_frame_r) begin
        if (fill_r != 2'd3) begin
          // fill the window and start the partial CRCs
          case (fill_r)
            2'd0:    win_nxt[0] = in_byte_r;
            2'd1:    win_nxt[1] = in_byte_r;
            default: win_nxt[2] = in_byte_r;
          endcase
          crc_a_nxt = crc16_byte((fill_r == 2'd0) ? CRC_INIT : crc_a_r, in_byte_r);
          crc_b_nxt = crc16_byte((fill_r <= 2'd1) ? CRC_INIT : crc_b_r, in_byte_r);
          crc_c_nxt = crc16_byte(CRC_INIT, in_byte_r);
          fill_nxt  = fill_r + 2'd1;
        end else if (hdr_ok) begin
          // header found: enter the frame
          crc_nxt      = crc16_byte(crc_a_r, in_byte_r);
          length_nxt   = win_len;
          pos_nxt      = LW'(POS_TYPE);
          in_frame_nxt = 1'b1;
          fill_nxt     = 2'd0;
        end else begin
          // slide on by one byte and shift the partial CRCs along
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = in_byte_r;
          crc_a_nxt  = crc16_byte(crc_b_r, in_byte_r);
          crc_b_nxt  = crc16_byte(crc_c_r, in_byte_r);
          crc_c_nxt  = crc16_byte(CRC_INIT, in_byte_r);
        end
      end else begin
        if (pos_r < len_m2) begin
          crc_nxt = crc16_byte(crc_r, in_byte_r);
        end
        case (pos_r)
          LW'(POS_TYPE):     type_nxt          = in_byte_r;
          LW'(POS_SENDER):   sender_nxt        = in_byte_r;
          LW'(POS_RECEIVER): receiver_nxt      = in_byte_r;
          LW'(POS_SEQ_LO):   seq_nxt[7:0]      = in_byte_r;
          LW'(POS_SEQ_HI):   seq_nxt[15:8]     = in_byte_r;
          LW'(POS_CMD_SET):  cmd_set_nxt       = in_byte_r;
          LW'(POS_CMD_ID):   cmd_id_nxt        = in_byte_r;
          default: begin
            if (pos_r == len_m2) begin
              crc_lo_nxt = in_byte_r;
            end
          end
        endcase
        if (pos_r == len_m1) begin
          // closing byte: back to hunting with an empty window
          in_frame_nxt = 1'b0;
          fill_nxt     = 2'd0;
          pos_nxt      = '0;
        end else begin
          pos_nxt = pos_r + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 2'd0;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      length_r   <= '0;
    end else begin
      fill_r     <= fill_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      length_r   <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    crc_a_r    <= crc_a_nxt;
    crc_b_r    <= crc_b_nxt;
    crc_c_r    <= crc_c_nxt;
    crc_r      <= crc_nxt;
    crc_lo_r   <= crc_lo_nxt;
    type_r     <= type_nxt;
    sender_r   <= sender_nxt;
    receiver_r <= receiver_nxt;
    seq_r      <= seq_nxt;
    cmd_set_r  <= cmd_set_nxt;
    cmd_id_r   <= cmd_id_nxt;
  end

  // result buffer
  sbcc_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (proc_fire && has_result),
    .push_ready (sk_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data)
  );

  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_valid = out_data.payload_valid;
  assign out_frame_end     = out_data.frame_end;
  assign out_crc_ok        = out_data.crc_ok;
  assign out_is_ack        = out_data.is_ack;
  assign out_cmd_type      = out_data.cmd_type;
  assign out_sender        = out_data.sender;
  assign out_receiver      = out_data.receiver;
  assign out_sequence_res  = out_data.sequence_res;
  assign out_command_set   = out_data.command_set;
  assign out_command_id    = out_data.command_id;
  assign out_frame_length  = out_data.frame_length;

  // checks
  `SBCC_ASSERT_SAME(a_pos_in_range, in_frame_r, (pos_r >= LW'(POS_TYPE)) && (pos_r < length_r), "frame position outside the stored length")
  `SBCC_ASSERT_SAME(a_len_min, in_frame_r, CMP_W'(length_r) >= CMP_W'(MIN_FRAME_LEN), "frame entered with a length below the minimum")
  `SBCC_ASSERT_NEXT(a_end_to_hunt, proc_fire && in_frame_r && (pos_r == len_m1), !in_frame_r && (fill_r == 2'd0), "frame end did not return to hunting")
  `SBCC_ASSERT_SAME(a_result_kind, out_valid, !(out_payload_valid && out_frame_end), "result is both payload and frame end")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sof_bcc_crc16_frame_deframer_core: streams good, corrupt and
// noisy frames through the byte channel and checks every record against a built-in deframer.
// Depends on sbcc_pkg and the core RTL.
module tb_top;
  import sbcc_pkg::*;

  localparam int          TOTAL_ITEMS  = 1750;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [15:0] CRC_SEED     = 16'hFFFF;
  localparam logic [15:0] CRC_GEN      = 16'h1021;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum {BAD_SOF, BAD_BCC, SHORT_LEN} break_e;

  // Deframer predictor plus the store of records still owed by the block
  class deframe_checker;
    logic [7:0]      sof_byte;
    logic [9:0]      min_len;
    logic [7:0]      ack_bits;
    logic [2:0][7:0] window;
    int unsigned     fill;
    bit              framing;
    int unsigned     pos;
    int unsigned     flen;
    logic [15:0]     crc;
    logic [7:0]      crc_lo;
    logic [7:0]      type_b;
    logic [7:0]      sender_b;
    logic [7:0]      receiver_b;
    logic [15:0]     seq;
    logic [7:0]      cmd_set_b;
    logic [7:0]      cmd_id_b;
    result_t         records[$];
    int              errors;
    int              printed;

    function new();
      sof_byte   = SOF_RESET;
      min_len    = MIN_LEN_RESET;
      ack_bits   = ACK_MASK_RESET;
      window     = '0;
      fill       = 0;
      framing    = 1'b0;
      pos        = 0;
      flen       = 0;
      crc        = CRC_SEED;
      crc_lo     = 8'h00;
      type_b     = 8'h00;
      sender_b   = 8'h00;
      receiver_b = 8'h00;
      seq        = 16'h0000;
      cmd_set_b  = 8'h00;
      cmd_id_b   = 8'h00;
      errors     = 0;
      printed    = 0;
    endfunction

    // CRC-16, one data bit at a time, MSB first
    function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      int          i;
      c = c_in;
      for (i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ CRC_GEN;
        end
      end
      return c;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SOF_VALUE) begin
        sof_byte = data[7:0];
      end else if (idx == REG_MIN_LENGTH) begin
        min_len = data[9:0];
      end else if (idx == REG_ACK_MASK) begin
        ack_bits = data[7:0];
      end
    endfunction

    function result_t make_record(input logic [7:0] pbyte, input logic pvalid,
                                  input logic fend, input logic ok);
      result_t r;
      r.payload_byte  = pbyte;
      r.payload_valid = pvalid;
      r.frame_end     = fend;
      r.crc_ok        = ok;
      r.is_ack        = |(type_b & ack_bits);
      r.cmd_type      = type_b;
      r.sender        = sender_b;
      r.receiver      = receiver_b;
      r.sequence_res  = seq;
      r.command_set   = cmd_set_b;
      r.command_id    = cmd_id_b;
      r.frame_length  = flen[9:0];
      return r;
    endfunction

    // Advance the deframer by one accepted byte
    function void take_byte(input logic [7:0] b);
      int unsigned floor_len;
      int unsigned cand_len;
      if (!framing) begin
        if (fill < 3) begin
          window[fill] = b;
          fill++;
          return;
        end
        cand_len  = 32'({window[2][1:0], window[1]});
        floor_len = 32'((min_len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : min_len);
        if (window[0] == sof_byte && cand_len >= floor_len &&
            (window[0] ^ window[1] ^ window[2]) == b) begin
          crc = crc_step(crc_step(crc_step(crc_step(CRC_SEED, window[0]), window[1]),
                                  window[2]), b);
          flen    = cand_len;
          pos     = 4;
          framing = 1'b1;
          fill    = 0;
        end else begin
          // drop the oldest byte and keep the new one
          window = {b, window[2], window[1]};
        end
        return;
      end

      if (pos < flen - 2) begin
        crc = crc_step(crc, b);
      end
      case (pos)
        POS_TYPE:     type_b = b;
        POS_SENDER:   sender_b = b;
        POS_RECEIVER: receiver_b = b;
        POS_SEQ_LO:   seq[7:0] = b;
        POS_SEQ_HI:   seq[15:8] = b;
        POS_CMD_SET:  cmd_set_b = b;
        POS_CMD_ID:   cmd_id_b = b;
        default: begin
          if (pos == flen - 2) begin
            crc_lo = b;
          end else if (pos == flen - 1) begin
            records.push_back(make_record(8'h00, 1'b0, 1'b1, {b, crc_lo} == crc));
            framing = 1'b0;
            fill    = 0;
            pos     = 0;
            return;
          end else begin
            records.push_back(make_record(b, 1'b1, 1'b0, 1'b0));
          end
        end
      endcase
      pos++;
    endfunction

    task report(input string msg);
      errors++;
      if (printed < 40) begin
        $display("%0t: %s", $time, msg);
        printed++;
      end
    endtask

    task compare(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h expected %0h", name, got, want));
      end
    endtask

    task check_record(input result_t got);
      result_t want;
      if (records.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = records.pop_front();
      compare("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      compare("payload_valid", 16'(got.payload_valid), 16'(want.payload_valid));
      compare("frame_end", 16'(got.frame_end), 16'(want.frame_end));
      compare("crc_ok", 16'(got.crc_ok), 16'(want.crc_ok));
      compare("is_ack", 16'(got.is_ack), 16'(want.is_ack));
      compare("cmd_type", 16'(got.cmd_type), 16'(want.cmd_type));
      compare("sender", 16'(got.sender), 16'(want.sender));
      compare("receiver", 16'(got.receiver), 16'(want.receiver));
      compare("sequence_res", got.sequence_res, want.sequence_res);
      compare("command_set", 16'(got.command_set), 16'(want.command_set));
      compare("command_id", 16'(got.command_id), 16'(want.command_id));
      compare("frame_length", 16'(got.frame_length), 16'(want.frame_length));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_rx_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [7:0]             out_payload_byte;
  logic                   out_payload_valid;
  logic                   out_frame_end;
  logic                   out_crc_ok;
  logic                   out_is_ack;
  logic [7:0]             out_cmd_type;
  logic [7:0]             out_sender;
  logic [7:0]             out_receiver;
  logic [15:0]            out_sequence_res;
  logic [7:0]             out_command_set;
  logic [7:0]             out_command_id;
  logic [FRAME_LEN_W-1:0] out_frame_length;

  deframe_checker sb;
  logic [7:0]     tx_bytes[$];
  int             bytes_sent    = 0;
  int             hold_requests = 0;
  int             quiet_cycles  = 0;
  bit             in_calm       = 1'b0;
  bit             out_calm      = 1'b0;
  logic [7:0]     cur_sof       = SOF_RESET;
  int unsigned    cur_floor     = 32'(MIN_FRAME_LEN);

  sof_bcc_crc16_frame_deframer_core #(
    .LENGTH_BITS(10)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_frame_end    (out_frame_end),
    .out_crc_ok       (out_crc_ok),
    .out_is_ack       (out_is_ack),
    .out_cmd_type     (out_cmd_type),
    .out_sender       (out_sender),
    .out_receiver     (out_receiver),
    .out_sequence_res (out_sequence_res),
    .out_command_set  (out_command_set),
    .out_command_id   (out_command_id),
    .out_frame_length (out_frame_length)
  );

  always #4 clk = ~clk;

  // Observe both channels at each edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.take_byte(in_rx_byte);
      end
      if (out_valid && out_ready) begin
        got.payload_byte  = out_payload_byte;
        got.payload_valid = out_payload_valid;
        got.frame_end     = out_frame_end;
        got.crc_ok        = out_crc_ok;
        got.is_ack        = out_is_ack;
        got.cmd_type      = out_cmd_type;
        got.sender        = out_sender;
        got.receiver      = out_receiver;
        got.sequence_res  = out_sequence_res;
        got.command_set   = out_command_set;
        got.command_id    = out_command_id;
        got.frame_length  = out_frame_length;
        sb.check_record(got);
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result sink: random backpressure, plus a long hold-off on request
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= out_calm || ($urandom_range(99) >= 21);
    end
  end

  // Offer one byte, idling first at random, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    if (!in_calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 21) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queued(input int n);
    repeat (n) send_byte(tx_bytes.pop_front());
  endtask

  // Drop valid and wait until every owed record is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write all registers; unused upper data bits get random values
  task automatic configure(input logic [7:0] sof, input logic [9:0] min_len,
                           input logic [7:0] ack);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[7:0] = sof;
    write_reg(REG_SOF_VALUE, data);
    write_reg(REG_MIN_LENGTH, min_len);
    data = CFG_DATA_W'($urandom);
    data[7:0] = ack;
    write_reg(REG_ACK_MASK, data);
    data = CFG_DATA_W'($urandom);
    write_reg(REG_SPARE, data);
    cfg_wr_en <= 1'b0;
    cur_sof   = sof;
    cur_floor = 32'((min_len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : min_len);
  endtask

  // Build one frame into tx_bytes; the length field's unused high bits follow the fill
  task automatic build_frame(input int unsigned len, input bit good_crc, input fill_e fill);
    logic [7:0]  h0, h1, h2, b;
    logic [15:0] c;
    int          i;
    int          k;
    b  = 8'($urandom);
    h0 = cur_sof;
    h1 = len[7:0];
    h2 = {b[7:2], len[9:8]};
    if (fill == FILL_ZERO) begin
      h2[7:2] = '0;
    end else if (fill == FILL_ONES) begin
      h2[7:2] = '1;
    end
    tx_bytes.delete();
    c = CRC_SEED;
    for (i = 0; i < len - 2; i++) begin
      if (i == 0) begin
        b = h0;
      end else if (i == 1) begin
        b = h1;
      end else if (i == 2) begin
        b = h2;
      end else if (i == 3) begin
        b = h0 ^ h1 ^ h2;
      end else if (fill == FILL_ZERO) begin
        b = 8'h00;
      end else if (fill == FILL_ONES) begin
        b = 8'hFF;
      end else begin
        b = 8'($urandom);
      end
      tx_bytes.push_back(b);
      c = sb.crc_step(c, b);
    end
    // corrupt one CRC bit
    if (!good_crc) begin
      k = $urandom_range(15);
      c[k] = ~c[k];
    end
    tx_bytes.push_back(c[7:0]);
    tx_bytes.push_back(c[15:8]);
  endtask

  // Four header bytes that fail on exactly one check
  task automatic send_broken();
    logic [7:0]  h0, h1, h2, bcc, r;
    logic [9:0]  l;
    break_e      kind;
    kind = break_e'($urandom_range(2));
    r    = 8'($urandom);
    h0   = cur_sof;
    if (kind == SHORT_LEN) begin
      l = 10'($urandom_range(0, cur_floor - 1));
    end else begin
      l = 10'($urandom_range(cur_floor, 1023));
    end
    h1 = l[7:0];
    h2 = {r[7:2], l[9:8]};
    if (kind == BAD_SOF) begin
      r  = 8'($urandom_range(1, 255));
      h0 = h0 ^ r;
    end
    bcc = h0 ^ h1 ^ h2;
    if (kind == BAD_BCC) begin
      r   = 8'($urandom_range(1, 255));
      bcc = bcc ^ r;
    end
    send_byte(h0);
    send_byte(h1);
    send_byte(h2);
    send_byte(bcc);
  endtask

  // Mostly well-formed frames with random content, the rest noise and broken headers
  task automatic run_phase(input int units);
    int          u;
    int unsigned len;
    for (u = 0; u < units; u++) begin
      if ($urandom_range(99) < 75) begin
        len = cur_floor + $urandom_range(0, 24);
        if ($urandom_range(9) == 0) begin
          len += $urandom_range(0, 150);
        end
        if (len > 1023) begin
          len = 1023;
        end
        build_frame(len, $urandom_range(99) < 85, FILL_RANDOM);
        send_queued(tx_bytes.size());
      end else if ($urandom_range(1) == 0) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        send_broken();
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: header one short of the minimum length, then slide into
    // an all-ones frame with a bad CRC and an all-zero frame with a good one
    send_byte(SOF_RESET);
    send_byte(8'h0C);
    send_byte(8'h00);
    send_byte(SOF_RESET ^ 8'h0C);
    build_frame(14, 1'b0, FILL_ONES);
    send_queued(tx_bytes.size());
    build_frame(14, 1'b1, FILL_ZERO);
    send_queued(tx_bytes.size());
    settle();

    // Reconfigure in the middle of a frame; it must finish at its own length
    build_frame(20, 1'b1, FILL_RANDOM);
    send_queued(13);
    settle();
    configure(8'h00, 10'd1023, 8'hFF);
    send_queued(tx_bytes.size());
    settle();

    // Longest frame while the sink holds off long enough to stall the input
    send_broken();
    hold_requests <= hold_requests + 1;
    build_frame(1023, 1'b1, FILL_RANDOM);
    send_queued(tx_bytes.size());
    settle();

    // Random phases, each under a fresh setting; the first runs without idling
    phase = 0;
    while (bytes_sent < TOTAL_ITEMS) begin
      settle();
      in_calm  = (phase == 0);
      out_calm = (phase == 0);
      case (phase)
        0:       configure(8'($urandom), MIN_FRAME_LEN, 8'($urandom));
        1:       configure(8'hFF, 10'd0, 8'h00);
        2:       configure(8'($urandom), 10'($urandom_range(1, 12)), 8'($urandom));
        default: configure(8'($urandom), 10'($urandom_range(13, 40)), 8'($urandom));
      endcase
      run_phase((phase == 0) ? 12 : 6);
      phase++;
    end

    settle();
    if (out_valid) begin
      sb.report("result left over after the last item");
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
